/* rtl/urss_pkg.sv */
// ----------------------------------------------------------------------------
// urss_pkg: shared types and constants of the range-to-display unit
// Holds the controller states, the command and status bundles, the register
// map and the seven-segment lookup that the modules of the unit share.
// ----------------------------------------------------------------------------
package urss_pkg;

	// Display geometry and limits.
	localparam int NUM_DIGITS = 3;
	localparam int DIGIT_W    = $clog2(NUM_DIGITS);

	// Arithmetic widths: a 16-bit count times an 8-bit scale gives 24 bits.
	localparam int COUNT_W = 16;
	localparam int SCALE_W = 8;
	localparam int PROD_W  = COUNT_W + SCALE_W;
	localparam int DIST_W  = 16;
	localparam int RUN_W   = 4;
	localparam int SEG_W   = 8;
	localparam int BIN_W   = 10;
	localparam int BCD_W   = 4 * NUM_DIGITS;

	// Iteration counts of the shared serial units.
	localparam int DIV_STEPS = PROD_W;
	localparam int BCD_STEPS = BIN_W;
	localparam int STEP_W    = $clog2(DIV_STEPS);

	localparam logic [BIN_W-1:0] SHOW_MAX  = BIN_W'(999);
	localparam logic [SEG_W-1:0] DARK_CODE = 8'hFF;

	// Configuration port.
	localparam int PADDR_W = 4;
	localparam int PDATA_W = 32;
	localparam logic [1:0] REG_US_PER_COUNT  = 2'd0;
	localparam logic [1:0] REG_US_PER_CM     = 2'd1;
	localparam logic [1:0] REG_CONFIRM_COUNT = 2'd2;

	localparam logic [SCALE_W-1:0] US_PER_COUNT_RST  = 8'd12;
	localparam logic [SCALE_W-1:0] US_PER_CM_RST     = 8'd58;
	localparam logic [RUN_W-1:0]   CONFIRM_COUNT_RST = 4'd3;

	// Controller states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_DIV,
		ST_CMP,
		ST_BCD,
		ST_SEG,
		ST_DONE
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic mul;
		logic div_step;
		logic cmp;
		logic bcd_step;
		logic seg_load;
		logic out_load;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_scan;
		logic update;
	} sts_t;

	// Active-low seven-segment pattern of one decimal digit.
	function automatic logic [SEG_W-1:0] seg_code(input logic [3:0] digit);
		logic [SEG_W-1:0] code;
		unique case (digit)
			4'd0: code = 8'hC0;
			4'd1: code = 8'hF9;
			4'd2: code = 8'hA4;
			4'd3: code = 8'hB0;
			4'd4: code = 8'h99;
			4'd5: code = 8'h92;
			4'd6: code = 8'h82;
			4'd7: code = 8'hF8;
			4'd8: code = 8'h80;
			4'd9: code = 8'h90;
			default: code = DARK_CODE;
		endcase
		return code;
	endfunction

endpackage

/* rtl/urss_ctrl.sv */
// ----------------------------------------------------------------------------
// urss_ctrl: sequencing controller of the range-to-display unit
// Takes one transaction at a time and steps the datapath through multiply,
// serial division, comparison and, on an update, binary-to-BCD conversion
// and segment load (a scan tick skips them all); owns the output valid flag.
// ----------------------------------------------------------------------------
module urss_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	input  urss_pkg::sts_t  sts,
	output urss_pkg::cmd_t  cmd
);
	import urss_pkg::*;

	state_t              state_q, state_d;
	logic [STEP_W-1:0]   step_q, step_d;
	logic                out_valid_q;

	// State and step counter registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d  = state_q;
		step_d   = step_q;
		cmd      = '0;
		in_ready = (state_q == ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_START;
				end
			end
			ST_START: begin
				if (sts.is_scan) begin
					state_d = ST_DONE;
				end else begin
					cmd.mul = 1'b1;
					step_d  = '0;
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (step_q == STEP_W'(DIV_STEPS - 1)) begin
					state_d = ST_CMP;
				end else begin
					step_d = step_q + 1'b1;
				end
			end
			ST_CMP: begin
				cmd.cmp = 1'b1;
				step_d  = '0;
				if (sts.update) begin
					state_d = ST_BCD;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_BCD: begin
				cmd.bcd_step = 1'b1;
				if (step_q == STEP_W'(BCD_STEPS - 1)) begin
					state_d = ST_SEG;
				end else begin
					step_d = step_q + 1'b1;
				end
			end
			ST_SEG: begin
				cmd.seg_load = 1'b1;
				state_d      = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Output valid flag: set when a result is loaded, cleared once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	// An accepted transaction always leaves the idle state.
	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q != ST_IDLE)
		else $error("accepted transaction did not start processing");

	// The division runs for exactly its full number of steps.
	a_div_length: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV && step_q == STEP_W'(DIV_STEPS - 1) |=> state_q == ST_CMP)
		else $error("division did not end after its last step");

	// A waiting result is never overwritten.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |-> !cmd.out_load)
		else $error("output register overwritten while stalled");

endmodule

/* rtl/urss_dpath.sv */
// ----------------------------------------------------------------------------
// urss_dpath: datapath of the range-to-display unit
// Holds the captured item, the serial restoring divider, the confirmation
// run, the shown value, the shift-and-add-3 BCD converter, the digit codes,
// the scan position and the output register.
// ----------------------------------------------------------------------------
module urss_dpath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  urss_pkg::cmd_t                cmd,
	output urss_pkg::sts_t                sts,
	input  logic                          mode,
	input  logic [urss_pkg::COUNT_W-1:0]  echo_count,
	input  logic                          echo_seen,
	input  logic [urss_pkg::SCALE_W-1:0]  us_per_count,
	input  logic [urss_pkg::SCALE_W-1:0]  us_per_cm,
	input  logic [urss_pkg::RUN_W-1:0]    confirm_count,
	output logic [urss_pkg::DIST_W-1:0]   distance_cm,
	output logic                          display_updated,
	output logic [urss_pkg::SEG_W-1:0]    segment_code,
	output logic [urss_pkg::DIGIT_W-1:0]  digit_select
);
	import urss_pkg::*;

	// Captured item.
	logic                 mode_q;
	logic [COUNT_W-1:0]   count_q;
	logic                 seen_q;

	// Divider and result.
	logic [SCALE_W-1:0]   rem_q;
	logic [PROD_W-1:0]    quo_q;
	logic [DIST_W-1:0]    dist_q;
	logic                 upd_q;

	// Display state.
	logic [DIST_W-1:0]    shown_q;
	logic [RUN_W-1:0]     run_q;
	logic [BIN_W-1:0]     bin_q;
	logic [BCD_W-1:0]     bcd_q;
	logic [SEG_W-1:0]     codes_q [NUM_DIGITS];
	logic [DIGIT_W-1:0]   scan_q;

	// Output register.
	logic [DIST_W-1:0]    distance_q;
	logic                 updated_q;
	logic [SEG_W-1:0]     seg_q;
	logic [DIGIT_W-1:0]   sel_q;

	// Combinational helpers.
	logic [SCALE_W-1:0]   divisor;
	logic [SCALE_W:0]     trial;
	logic                 trial_ge;
	logic [DIST_W-1:0]    dist_sat;
	logic [RUN_W-1:0]     need;
	logic [RUN_W-1:0]     run_inc;
	logic                 differs;
	logic [BIN_W-1:0]     show_val;
	logic [BCD_W-1:0]     bcd_adj;
	logic [DIGIT_W-1:0]   pos;
	logic [DIGIT_W-1:0]   pos_next;

	// Divider step: shift in the next dividend bit and try a subtraction.
	always_comb begin
		divisor  = (us_per_cm == '0) ? SCALE_W'(1) : us_per_cm;
		trial    = {rem_q, quo_q[PROD_W-1]};
		trial_ge = (trial >= {1'b0, divisor});
	end

	// Saturated distance, confirmation run and update decision.
	always_comb begin
		dist_sat = (|quo_q[PROD_W-1:DIST_W]) ? '1 : quo_q[DIST_W-1:0];
		need     = (confirm_count == '0) ? RUN_W'(1) : confirm_count;
		run_inc  = (run_q == '1) ? run_q : run_q + 1'b1;
		differs  = (dist_sat != shown_q);
		show_val = (dist_sat > DIST_W'(SHOW_MAX)) ? SHOW_MAX : dist_sat[BIN_W-1:0];
		sts.update  = differs && (run_inc >= need);
		sts.is_scan = mode_q;
	end

	// Shift-and-add-3 correction of each BCD digit before the shift.
	always_comb begin
		for (int d = 0; d < NUM_DIGITS; d++) begin
			bcd_adj[4*d +: 4] = (bcd_q[4*d +: 4] >= 4'd5) ?
				bcd_q[4*d +: 4] + 4'd3 : bcd_q[4*d +: 4];
		end
	end

	// Scan position, folded back to the ones digit when out of range.
	always_comb begin
		pos      = (scan_q < DIGIT_W'(NUM_DIGITS)) ? scan_q : '0;
		pos_next = (pos == DIGIT_W'(NUM_DIGITS - 1)) ? '0 : pos + 1'b1;
	end

	// Item capture, multiply, divide and BCD working registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q  <= mode;
			count_q <= echo_count;
			seen_q  <= echo_seen;
		end
		if (cmd.mul) begin
			rem_q <= '0;
			quo_q <= seen_q ? PROD_W'(count_q) * PROD_W'(us_per_count) : '0;
		end else if (cmd.div_step) begin
			rem_q <= trial_ge ? SCALE_W'(trial - {1'b0, divisor}) : trial[SCALE_W-1:0];
			quo_q <= {quo_q[PROD_W-2:0], trial_ge};
		end
		if (cmd.cmp) begin
			dist_q <= dist_sat;
			upd_q  <= sts.update;
			bin_q  <= show_val;
			bcd_q  <= '0;
		end else if (cmd.bcd_step) begin
			bcd_q <= {bcd_adj[BCD_W-2:0], bin_q[BIN_W-1]};
			bin_q <= {bin_q[BIN_W-2:0], 1'b0};
		end
	end

	// Shown value and confirmation run.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shown_q <= '0;
			run_q   <= '0;
		end else if (cmd.cmp) begin
			if (!differs || sts.update) begin
				run_q <= '0;
			end else begin
				run_q <= run_inc;
			end
			if (sts.update) begin
				shown_q <= dist_sat;
			end
		end
	end

	// Digit codes and scan position.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int d = 0; d < NUM_DIGITS; d++) begin
				codes_q[d] <= '0;
			end
			scan_q <= '0;
		end else begin
			if (cmd.seg_load) begin
				for (int d = 0; d < NUM_DIGITS; d++) begin
					codes_q[d] <= seg_code(bcd_q[4*d +: 4]);
				end
			end
			if (cmd.out_load && mode_q) begin
				scan_q <= pos_next;
			end
		end
	end

	// Output register.
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			if (mode_q) begin
				distance_q <= '0;
				updated_q  <= 1'b0;
				seg_q      <= codes_q[pos];
				sel_q      <= pos;
			end else begin
				distance_q <= dist_q;
				updated_q  <= upd_q;
				seg_q      <= DARK_CODE;
				sel_q      <= '0;
			end
		end
	end

	assign distance_cm     = distance_q;
	assign display_updated = updated_q;
	assign segment_code    = seg_q;
	assign digit_select    = sel_q;

	// The converted digits are all decimal when the codes are loaded.
	a_bcd_decimal: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.seg_load |-> (bcd_q[3:0] <= 4'd9) && (bcd_q[7:4] <= 4'd9) &&
			(bcd_q[11:8] <= 4'd9))
		else $error("BCD conversion produced a non-decimal digit");

	// An update takes the new distance and restarts the run.
	a_update_commits: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cmp && sts.update |=> (run_q == '0) && (shown_q == dist_q))
		else $error("display update did not commit the new distance");

endmodule

/* rtl/ultrasonic_range_to_seven_seg_unit.sv */
// ----------------------------------------------------------------------------
// ultrasonic_range_to_seven_seg_unit: echo count to three-digit display
// Input channel (in_valid/in_ready) carries one transaction per item: mode 0
// is a measurement (echo_count, echo_seen), mode 1 is a display scan tick.
// Output channel (out_valid/out_ready) returns exactly one result per item.
// A measurement is multiplied, divided by the one-bit-per-cycle restoring
// divider, compared and, when the display is updated, converted by the serial
// binary-to-BCD converter and loaded into the digit codes; a scan tick goes
// straight to the output register. The divider sets the throughput: one
// item at a time, a new item accepted only once the previous result has
// entered the output register. A stalled receiver holds the
// result in the output register; the unit then finishes the next item and
// waits for the register to free. Reset clears the shown value, the run
// count, the scan position and the digit codes (all segments lit), and
// loads the register defaults 12, 58 and 3. The APB port holds
// us_per_count at 0x0, us_per_cm at 0x4 and confirm_count at 0x8; write it
// only while the unit is idle.
// ----------------------------------------------------------------------------
module ultrasonic_range_to_seven_seg_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          mode,
	input  logic [urss_pkg::COUNT_W-1:0]  echo_count,
	input  logic                          echo_seen,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [urss_pkg::DIST_W-1:0]   distance_cm,
	output logic                          display_updated,
	output logic [urss_pkg::SEG_W-1:0]    segment_code,
	output logic [urss_pkg::DIGIT_W-1:0]  digit_select,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [urss_pkg::PADDR_W-1:0]  paddr,
	input  logic [urss_pkg::PDATA_W-1:0]  pwdata,
	output logic [urss_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready
);
	import urss_pkg::*;

	logic [SCALE_W-1:0] us_per_count_q;
	logic [SCALE_W-1:0] us_per_cm_q;
	logic [RUN_W-1:0]   confirm_count_q;
	logic [1:0]         reg_idx;
	logic               wr_en;
	cmd_t               cmd;
	sts_t               sts;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign wr_en   = psel && penable && pwrite;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			us_per_count_q  <= US_PER_COUNT_RST;
			us_per_cm_q     <= US_PER_CM_RST;
			confirm_count_q <= CONFIRM_COUNT_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_US_PER_COUNT:  us_per_count_q  <= pwdata[SCALE_W-1:0];
				REG_US_PER_CM:     us_per_cm_q     <= pwdata[SCALE_W-1:0];
				REG_CONFIRM_COUNT: confirm_count_q <= pwdata[RUN_W-1:0];
				default: ;
			endcase
		end
	end

	// Register read-back.
	always_comb begin
		unique case (reg_idx)
			REG_US_PER_COUNT:  prdata = PDATA_W'(us_per_count_q);
			REG_US_PER_CM:     prdata = PDATA_W'(us_per_cm_q);
			REG_CONFIRM_COUNT: prdata = PDATA_W'(confirm_count_q);
			default:           prdata = '0;
		endcase
	end

	urss_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	urss_dpath u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.mode            (mode),
		.echo_count      (echo_count),
		.echo_seen       (echo_seen),
		.us_per_count    (us_per_count_q),
		.us_per_cm       (us_per_cm_q),
		.confirm_count   (confirm_count_q),
		.distance_cm     (distance_cm),
		.display_updated (display_updated),
		.segment_code    (segment_code),
		.digit_select    (digit_select)
	);

endmodule

/* dv/tb_ultrasonic_range_to_seven_seg_unit.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ultrasonic_range_to_seven_seg_unit: self-checking bench of the range unit
// Sends measurement and display scan transactions through the valid/ready
// input channel and programs the scale and confirm registers over APB while
// the unit is idle. Each transaction is predicted by a scoreboard that keeps
// its own copy of the registers, the shown value, the differing-reading run,
// the digit patterns and the scan position. Each result is compared field by
// field with the oldest prediction. Both channels stall at random.
// ----------------------------------------------------------------------------
module tb_ultrasonic_range_to_seven_seg_unit;

	import urss_pkg::*;

	localparam logic MODE_MEASURE = 1'b0;
	localparam logic MODE_SCAN    = 1'b1;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int LONG_HOLD   = 300;
	localparam int SETTLE      = 50;
	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 225;

	// Active-low patterns of the digits 0 to 9, digit 0 in the lowest byte.
	localparam logic [79:0] DIGIT_SEGS = {
		8'h90, 8'h80, 8'hF8, 8'h82, 8'h92, 8'h99, 8'hB0, 8'hA4, 8'hF9, 8'hC0
	};

	typedef struct packed {
		logic [DIST_W-1:0]  distance_cm;
		logic               display_updated;
		logic [SEG_W-1:0]   segment_code;
		logic [DIGIT_W-1:0] digit_select;
	} range_result_t;

	// Predicts every result of the unit and holds those not yet returned.
	class range_display_scoreboard;
		logic [SCALE_W-1:0] us_per_count;
		logic [SCALE_W-1:0] us_per_cm;
		logic [RUN_W-1:0]   confirm_count;
		logic [DIST_W-1:0]  shown_cm;
		logic [RUN_W-1:0]   differ_run;
		logic [SEG_W-1:0]   digit_codes [NUM_DIGITS];
		logic [DIGIT_W-1:0] scan_pos;
		range_result_t      awaited_q [$];
		int                 errors;

		function new();
			us_per_count  = 8'd12;
			us_per_cm     = 8'd58;
			confirm_count = 4'd3;
			shown_cm      = '0;
			differ_run    = '0;
			scan_pos      = '0;
			errors        = 0;
			foreach (digit_codes[i])
				digit_codes[i] = '0;
		endfunction

		function void write_reg(input logic [1:0] idx, input logic [31:0] value);
			case (idx)
				REG_US_PER_COUNT:  us_per_count  = value[SCALE_W-1:0];
				REG_US_PER_CM:     us_per_cm     = value[SCALE_W-1:0];
				REG_CONFIRM_COUNT: confirm_count = value[RUN_W-1:0];
				default: ;
			endcase
		endfunction

		// Works out the result of one accepted transaction and queues it.
		function void note_input(input logic m, input logic [15:0] c, input logic s);
			range_result_t     r;
			logic [23:0]       product;
			logic [23:0]       quotient;
			logic [SCALE_W-1:0] divisor;
			logic [RUN_W-1:0]  need;
			logic [DIST_W-1:0] dist_cm;
			int                shown;
			int                pos;
			r = '0;
			if (m == MODE_SCAN) begin
				pos = (scan_pos < NUM_DIGITS) ? int'(scan_pos) : 0;
				r.segment_code = digit_codes[pos];
				r.digit_select = DIGIT_W'(pos);
				scan_pos = (pos + 1 >= NUM_DIGITS) ? '0 : DIGIT_W'(pos + 1);
			end else begin
				dist_cm = '0;
				if (s) begin
					divisor  = (us_per_cm == 0) ? 8'd1 : us_per_cm;
					product  = 24'(c) * 24'(us_per_count);
					quotient = product / 24'(divisor);
					dist_cm = (quotient > 24'hFFFF) ? 16'hFFFF : quotient[15:0];
				end
				need = (confirm_count == 0) ? 4'd1 : confirm_count;
				// A matching reading breaks the run; a differing one extends it.
				if (dist_cm == shown_cm) begin
					differ_run = '0;
				end else begin
					if (differ_run != 4'hF)
						differ_run = differ_run + 1'b1;
					if (differ_run >= need) begin
						differ_run = '0;
						shown_cm   = dist_cm;
						shown      = (dist_cm > 999) ? 999 : int'(dist_cm);
						digit_codes[0] = DIGIT_SEGS[(shown % 10) * 8 +: 8];
						digit_codes[1] = DIGIT_SEGS[((shown / 10) % 10) * 8 +: 8];
						digit_codes[2] = DIGIT_SEGS[((shown / 100) % 10) * 8 +: 8];
						r.display_updated = 1'b1;
					end
				end
				r.distance_cm  = dist_cm;
				r.segment_code = DARK_CODE;
			end
			awaited_q.push_back(r);
		endfunction

		function void check_result(input range_result_t got);
			range_result_t want;
			if (awaited_q.size() == 0) begin
				$error("result with no transaction outstanding: %p", got);
				errors++;
				return;
			end
			want = awaited_q.pop_front();
			if (got.distance_cm !== want.distance_cm) begin
				$error("distance_cm: expected %0d, got %0d", want.distance_cm, got.distance_cm);
				errors++;
			end
			if (got.display_updated !== want.display_updated) begin
				$error("display_updated: expected %0d, got %0d",
					want.display_updated, got.display_updated);
				errors++;
			end
			if (got.segment_code !== want.segment_code) begin
				$error("segment_code: expected 0x%02h, got 0x%02h",
					want.segment_code, got.segment_code);
				errors++;
			end
			if (got.digit_select !== want.digit_select) begin
				$error("digit_select: expected %0d, got %0d", want.digit_select, got.digit_select);
				errors++;
			end
		endfunction

		function int pending();
			return awaited_q.size();
		endfunction
	endclass

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic                 mode;
	logic [COUNT_W-1:0]   echo_count;
	logic                 echo_seen;
	logic                 out_valid;
	logic                 out_ready;
	logic [DIST_W-1:0]    distance_cm;
	logic                 display_updated;
	logic [SEG_W-1:0]     segment_code;
	logic [DIGIT_W-1:0]   digit_select;
	logic                 psel;
	logic                 penable;
	logic                 pwrite;
	logic [PADDR_W-1:0]   paddr;
	logic [PDATA_W-1:0]   pwdata;
	logic [PDATA_W-1:0]   prdata;
	logic                 pready;

	range_display_scoreboard sb = new();
	int  n_accepted = 0;
	int  cycle_count = 0;
	bit  calm = 1'b0;
	bit  hold_done = 1'b0;

	ultrasonic_range_to_seven_seg_unit dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.mode            (mode),
		.echo_count      (echo_count),
		.echo_seen       (echo_seen),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.distance_cm     (distance_cm),
		.display_updated (display_updated),
		.segment_code    (segment_code),
		.digit_select    (digit_select),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.prdata          (prdata),
		.pready          (pready)
	);

	// 100 MHz clock.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Offers one transaction, after an optional gap, and waits for its acceptance.
	task automatic send_item(input logic m, input logic [15:0] c, input logic s);
		if (!calm && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		in_valid   <= 1'b1;
		mode       <= m;
		echo_count <= c;
		echo_seen  <= s;
		do
			@(posedge clk);
		while (!in_ready);
		sb.note_input(m, c, s);
		n_accepted++;
	endtask

	// One write: setup cycle, access cycle, then a return to idle on the bus.
	task automatic apb_write(input logic [1:0] idx, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	// One read: setup cycle, access cycle, then a return to idle on the bus.
	task automatic apb_read(input logic [1:0] idx, output logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {idx, 2'b00};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		value = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Waits for the unit to go idle, then writes all three registers and
	// reads each one back.
	task automatic configure(input int upc, input int upm, input int cc);
		logic [31:0] wr_val [3];
		logic [31:0] rd_val;
		logic [1:0]  idx [3];
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		idx[0] = REG_US_PER_COUNT;
		idx[1] = REG_US_PER_CM;
		idx[2] = REG_CONFIRM_COUNT;
		wr_val[0] = 32'(upc & 8'hFF);
		wr_val[1] = 32'(upm & 8'hFF);
		wr_val[2] = 32'(cc & 4'hF);
		for (int i = 0; i < 3; i++) begin
			apb_write(idx[i], wr_val[i]);
			sb.write_reg(idx[i], wr_val[i]);
			apb_read(idx[i], rd_val);
			if (rd_val !== wr_val[i]) begin
				$error("register %0d read-back: expected %0d, got %0d", idx[i], wr_val[i], rd_val);
				sb.errors++;
			end
		end
	endtask

	// Random traffic: mostly runs of identical readings, so that the display
	// gets through its confirmation, mixed with scan ticks and loose noise.
	task automatic run_random(input int n_items);
		int          sent;
		int          pick;
		int          run_len;
		int          span;
		int          divisor;
		logic [15:0] c;
		logic        s;
		sent    = 0;
		divisor = (sb.us_per_cm == 0) ? 1 : int'(sb.us_per_cm);
		span    = (sb.us_per_count == 0) ? 65535 : (1000 * divisor) / int'(sb.us_per_count);
		if (span > 65535)
			span = 65535;
		while (sent < n_items) begin
			pick = $urandom_range(0, 9);
			if (pick < 3) begin
				send_item(MODE_SCAN, 16'($urandom), 1'($urandom));
				sent++;
			end else if (pick < 8) begin
				c = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, span)) : 16'($urandom);
				s = ($urandom_range(0, 9) != 0);
				run_len = $urandom_range(1, int'(sb.confirm_count) + 2);
				repeat (run_len) begin
					send_item(MODE_MEASURE, c, s);
					sent++;
				end
			end else begin
				send_item(MODE_MEASURE, 16'($urandom), 1'($urandom));
				sent++;
			end
		end
	endtask

	// Result side: checks each transaction and stalls at random, once for a
	// long stretch so that the unit fills up and stalls its input.
	initial begin
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		out_ready <= 1'b1;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				sb.check_result('{distance_cm, display_updated, segment_code, digit_select});
			if (!hold_done && n_accepted >= 400) begin
				hold_done = 1'b1;
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				out_ready <= 1'b1;
			end else if (!calm && $urandom_range(0, 4) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
				out_ready <= 1'b1;
			end
		end
	end

	// Stimulus.
	initial begin
		arst_n     <= 1'b0;
		in_valid   <= 1'b0;
		mode       <= MODE_MEASURE;
		echo_count <= '0;
		echo_seen  <= 1'b0;
		psel       <= 1'b0;
		penable    <= 1'b0;
		pwrite     <= 1'b0;
		paddr      <= '0;
		pwdata     <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset defaults: all segments lit, the scan wrapping, a matching
		// reading, a confirmed update above the display limit.
		repeat (4) send_item(MODE_SCAN, 16'hFFFF, 1'b1);
		send_item(MODE_MEASURE, 16'hFFFF, 1'b0);
		repeat (3) send_item(MODE_MEASURE, 16'hFFFF, 1'b1);
		repeat (3) send_item(MODE_SCAN, 16'h0000, 1'b0);
		send_item(MODE_MEASURE, 16'h0000, 1'b1);
		send_item(MODE_MEASURE, 16'hFFFF, 1'b1);
		send_item(MODE_MEASURE, 16'h1234, 1'b1);

		// Largest scale: the distance saturates, confirmed at once.
		configure(255, 1, 1);
		repeat (2) send_item(MODE_MEASURE, 16'hFFFF, 1'b1);
		repeat (3) send_item(MODE_SCAN, 16'h5A5A, 1'b0);

		// Zero divisor and zero confirm count both act as one.
		configure(255, 0, 0);
		send_item(MODE_MEASURE, 16'h00FF, 1'b1);
		send_item(MODE_MEASURE, 16'h0001, 1'b1);
		repeat (3) send_item(MODE_SCAN, 16'hA5A5, 1'b1);

		// Random phases across several register settings; the last one runs
		// without stalls on either side.
		for (int ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: configure(12, 58, 3);
				1: configure(255, 1, 1);
				2: configure(1, 255, 15);
				3: configure(0, 0, 0);
				4: configure(200, 3, 2);
				7: configure(12, 58, 3);
				default: configure($urandom_range(1, 255), $urandom_range(1, 255),
					$urandom_range(1, 15));
			endcase
			calm = (ph == PHASES - 1);
			run_random(PHASE_ITEMS);
		end

		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
